### rtl/core/wqrm_pkg.sv
// Package with the beat types, operation and status codes, and state encoding of the wait queue.
`timescale 1ns / 1ps

package wqrm_pkg;

    localparam int PID_W = 8;
    localparam int CNT_OUT_W = 5;

    localparam logic [1:0] OP_ENQUEUE = 2'd0;
    localparam logic [1:0] OP_DEQUEUE = 2'd1;
    localparam logic [1:0] OP_REMOVE  = 2'd2;
    localparam logic [1:0] OP_PEEK    = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    typedef struct packed {
        logic [1:0]       op;
        logic [PID_W-1:0] pid;
    } cmd_beat_t;

    typedef struct packed {
        logic [1:0]           status;
        logic [PID_W-1:0]     out_pid;
        logic                 is_empty;
        logic [CNT_OUT_W-1:0] entry_count;
    } rsp_beat_t;

    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

endpackage

### rtl/core/wqrm_cell.sv
// One queue cell: holds an identifier, takes its neighbor's on a shift or a new one on a load.
`timescale 1ns / 1ps

module wqrm_cell
    import wqrm_pkg::*;
(
    input  logic             clk,
    input  cell_ctrl_t       ctrl,
    input  logic [PID_W-1:0] nbr_data,
    input  logic [PID_W-1:0] load_data,
    output logic [PID_W-1:0] data
);

    logic [PID_W-1:0] data_reg;
    logic [PID_W-1:0] data_next;

    always_comb
    begin
        if (ctrl.load)
        begin
            data_next = load_data;
        end
        else if (ctrl.shift)
        begin
            data_next = nbr_data;
        end
        else
        begin
            data_next = data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

### rtl/core/wait_queue_remove_by_id.sv
// Top level of the wait queue: a row of shifting cells under a small sequencer.
//
//  Channel | Signals                   | Beat type
//  --------+---------------------------+-----------
//  command | cmd_valid, cmd_stall, cmd | cmd_beat_t
//  result  | rsp_valid, rsp_stall, rsp | rsp_beat_t
//
// Enqueue, dequeue and peek finish in the cycle they are taken; the result
// is registered and shows on the next cycle.
// Remove rotates the live entries once through the cell row, one cell step
// per cycle, and then reports the result from the done state.
// Reset empties the queue; the cell contents are not cleared.
// A stalled result holds the next command until the result register frees.
`timescale 1ns / 1ps

module wait_queue_remove_by_id
    import wqrm_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_stall,
    input  cmd_beat_t cmd,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_beat_t rsp
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int IDX_W = $clog2(QUEUE_DEPTH);

    state_t state_reg;
    state_t state_next;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] steps_reg;
    logic [CNT_W-1:0] steps_next;
    logic             found_reg;
    logic             found_next;
    logic [PID_W-1:0] key_reg;
    logic [PID_W-1:0] key_next;
    logic [PID_W-1:0] hit_reg;
    logic [PID_W-1:0] hit_next;
    logic             rsp_valid_reg;
    logic             rsp_valid_next;
    rsp_beat_t        rsp_reg;
    rsp_beat_t        rsp_next;

    logic [PID_W-1:0] cell_data [QUEUE_DEPTH];
    cell_ctrl_t       cell_ctrl [QUEUE_DEPTH];
    logic [PID_W-1:0] load_data;
    logic [PID_W-1:0] head;
    logic             out_free;
    logic             cmd_take;
    logic             is_full;
    logic             is_zero;
    logic             drop;
    logic             shift_all;
    logic             load_tail;
    logic [IDX_W-1:0] load_idx;

    assign head     = cell_data[0];
    assign out_free = !rsp_valid_reg || !rsp_stall;
    assign cmd_take = (state_reg == S_IDLE) && out_free && cmd_valid;
    assign is_full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign is_zero  = (count_reg == '0);
    assign drop     = !found_reg && (head == key_reg);

    genvar i;
    generate
        for (i = 0; i < QUEUE_DEPTH; i++)
        begin : g_cell
            logic [PID_W-1:0] nbr;
            if (i == QUEUE_DEPTH - 1)
            begin : g_last
                assign nbr = '0;
            end
            else
            begin : g_mid
                assign nbr = cell_data[i+1];
            end

            assign cell_ctrl[i].shift = shift_all;
            assign cell_ctrl[i].load  = load_tail && (load_idx == IDX_W'(i));

            wqrm_cell u_cell (
                .clk       (clk),
                .ctrl      (cell_ctrl[i]),
                .nbr_data  (nbr),
                .load_data (load_data),
                .data      (cell_data[i])
            );
        end
    endgenerate

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_take && (cmd.op == OP_REMOVE) && !is_zero)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (steps_reg == CNT_W'(1))
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        count_next     = count_reg;
        steps_next     = steps_reg;
        found_next     = found_reg;
        key_next       = key_reg;
        hit_next       = hit_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        shift_all      = 1'b0;
        load_tail      = 1'b0;
        load_idx       = IDX_W'(count_reg);
        load_data      = cmd.pid;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_take)
                begin
                    rsp_valid_next   = 1'b1;
                    rsp_next.status  = ST_OK;
                    rsp_next.out_pid = '0;
                    case (cmd.op)
                        OP_ENQUEUE:
                        begin
                            if (is_full)
                            begin
                                rsp_next.status = ST_FULL;
                            end
                            else
                            begin
                                load_tail        = 1'b1;
                                count_next       = count_reg + CNT_W'(1);
                                rsp_next.out_pid = cmd.pid;
                            end
                        end
                        OP_DEQUEUE:
                        begin
                            if (is_zero)
                            begin
                                rsp_next.status = ST_EMPTY;
                            end
                            else
                            begin
                                shift_all        = 1'b1;
                                count_next       = count_reg - CNT_W'(1);
                                rsp_next.out_pid = head;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (is_zero)
                            begin
                                rsp_next.status = ST_EMPTY;
                            end
                            else
                            begin
                                rsp_valid_next = rsp_valid_reg && rsp_stall;
                                rsp_next       = rsp_reg;
                                steps_next     = count_reg;
                                found_next     = 1'b0;
                                key_next       = cmd.pid;
                            end
                        end
                        default:
                        begin
                            if (is_zero)
                            begin
                                rsp_next.status = ST_EMPTY;
                            end
                            else
                            begin
                                rsp_next.out_pid = head;
                            end
                        end
                    endcase
                    rsp_next.is_empty    = (count_next == '0);
                    rsp_next.entry_count = CNT_OUT_W'(count_next);
                end
            end
            S_SCAN:
            begin
                shift_all  = 1'b1;
                load_data  = head;
                load_idx   = IDX_W'(count_reg - CNT_W'(1));
                steps_next = steps_reg - CNT_W'(1);
                if (drop)
                begin
                    found_next = 1'b1;
                    hit_next   = head;
                    count_next = count_reg - CNT_W'(1);
                end
                else
                begin
                    load_tail = 1'b1;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    rsp_valid_next       = 1'b1;
                    rsp_next.status      = found_reg ? ST_OK : ST_NOTFOUND;
                    rsp_next.out_pid     = found_reg ? hit_reg : '0;
                    rsp_next.is_empty    = is_zero;
                    rsp_next.entry_count = CNT_OUT_W'(count_reg);
                end
            end
            default:
            begin
                rsp_valid_next = rsp_valid_reg && rsp_stall;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            steps_reg     <= '0;
            found_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            steps_reg     <= steps_next;
            found_reg     <= found_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        hit_reg <= hit_next;
        rsp_reg <= rsp_next;
    end

    assign cmd_stall = !((state_reg == S_IDLE) && out_free);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

### rtl/core/wqrm_checker.sv
// Port-level checker for the wait queue, bound to the top level.
`timescale 1ns / 1ps

module wqrm_assertions
    import wqrm_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      cmd_stall,
    input logic      rsp_valid,
    input logic      rsp_stall,
    input rsp_beat_t rsp
);

    // A stalled result beat stays and does not change.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("result beat changed while stalled");

    // No command beat is taken while a result beat waits.
    a_cmd_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |-> cmd_stall)
        else $error("command taken while a result beat waits");

    // A failed operation reports no identifier.
    a_fail_pid: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status != ST_OK) |-> (rsp.out_pid == '0))
        else $error("identifier reported on a failed operation");

    // An empty status means the queue is empty.
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == ST_EMPTY) |-> rsp.is_empty)
        else $error("empty status on a queue that holds entries");

    // A full status means the queue holds entries.
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == ST_FULL) |-> !rsp.is_empty)
        else $error("full status on an empty queue");

endmodule

bind wait_queue_remove_by_id wqrm_assertions u_wqrm_assertions (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_stall (cmd_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);
